### rtl/core/iqlms_pkg.sv
// iqlms_pkg: types and constants shared by the iq imbalance lms corrector
// no dependencies; used by iqlms_coef_ram, iqlms_datapath and the top level
package iqlms_pkg;

  localparam int unsigned BIN_INDEX_W    = 7;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned STEP_SHIFT_W   = 4;
  localparam int unsigned Q15_SHIFT      = 15;
  localparam logic [3:0]  STEP_SHIFT_RST = 4'd12;

  // one mirror pair of fft bins
  typedef struct packed {
    logic        [BIN_INDEX_W-1:0] bin_index;
    logic signed [SAMPLE_W-1:0]    bin_re;
    logic signed [SAMPLE_W-1:0]    bin_im;
    logic signed [SAMPLE_W-1:0]    mirror_re;
    logic signed [SAMPLE_W-1:0]    mirror_im;
  } in_item_t;

  // corrected pair
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] fixed_re;
    logic signed [SAMPLE_W-1:0] fixed_im;
    logic signed [SAMPLE_W-1:0] fixed_mirror_re;
    logic signed [SAMPLE_W-1:0] fixed_mirror_im;
  } out_item_t;

  // complex q15 leakage coefficient, one table entry
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } coef_t;

endpackage

### rtl/core/fft_iq_imbalance_lms_correct.sv
// fft_iq_imbalance_lms_correct: top level of the frequency-domain iq imbalance corrector
// depends on iqlms_pkg, iqlms_coef_ram and iqlms_datapath
//
//  channel | ports                              | transaction
//  --------+------------------------------------+------------------------------------
//  in      | in_valid, in_ready, in_data        | bin index, bin k and mirror bin
//  out     | out_valid, out_ready, out_data     | corrected bin k and mirror bin
//  cfg     | cfg_valid, cfg_ready, cfg_step_shift | lms step shift, always ready
//
//  one transaction per cycle while each bin's table entry is not in flight and the output is not stalled;
//  a bin whose entry is still in the read-modify-write loop (four pipeline stages
//  between table read and write-back) waits until that entry is written back; an accepted
//  bin passes stages a to d and the output register before out_valid rises
//  after reset a clearing pass zeroes the whole table, in_ready low
//  a stalled output fills pipeline bubbles before in_ready drops
module fft_iq_imbalance_lms_correct #(
  parameter int unsigned N_FFT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  iqlms_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output iqlms_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_step_shift
);

  // table depth is half the fft size; the user must keep the fft size a power of two, the block does not enforce it
  localparam int unsigned DEPTH  = N_FFT / 2;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [3:0]          step_shift_r;
  logic                clr_active_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [ADDR_W-1:0]   in_idx;
  logic                in_fire;
  logic                dp_take_ok;
  logic                dp_hit;
  logic                dp_we;
  logic [ADDR_W-1:0]   dp_waddr;
  iqlms_pkg::coef_t    dp_wdata;
  iqlms_pkg::coef_t    ram_rdata;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  iqlms_pkg::coef_t    ram_wdata;

  // index wraps modulo the table depth
  generate
    if (ADDR_W <= iqlms_pkg::BIN_INDEX_W) begin : g_idx_trunc
      assign in_idx = in_data.bin_index[ADDR_W-1:0];
    end else begin : g_idx_ext
      assign in_idx = {{(ADDR_W - iqlms_pkg::BIN_INDEX_W){1'b0}}, in_data.bin_index};
    end
  endgenerate

  // step shift register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_shift_r <= iqlms_pkg::STEP_SHIFT_RST;
    end else if (cfg_valid) begin
      step_shift_r <= cfg_step_shift;
    end
  end

  // clearing pass: one table entry zeroed per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // accept after the clearing pass when stage a is free and the entry is not in flight
  assign in_ready = !clr_active_r && dp_take_ok && !dp_hit;
  assign in_fire  = in_valid && in_ready;

  // table write port shared by the clearing pass and write-back
  assign ram_we    = clr_active_r || dp_we;
  assign ram_waddr = clr_active_r ? clr_cnt_r : dp_waddr;
  assign ram_wdata = clr_active_r ? '0 : dp_wdata;

  iqlms_coef_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  iqlms_datapath #(
    .ADDR_W (ADDR_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_shift (step_shift_r),
    .in_fire    (in_fire),
    .in_item    (in_data),
    .in_idx     (in_idx),
    .take_ok    (dp_take_ok),
    .hit        (dp_hit),
    .coef_rd    (ram_rdata),
    .wb_we      (dp_we),
    .wb_addr    (dp_waddr),
    .wb_data    (dp_wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef ASSERT_OFF
  // the clearing pass ends only after the last entry
  a_clr_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_active_r) |-> ($past(clr_cnt_r) == ADDR_W'(DEPTH - 1)))
    else $error("clearing pass ended early");

  // no write-back can collide with the clearing pass
  a_no_wb_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
    dp_we |-> !clr_active_r)
    else $error("coefficient write-back during clearing pass");
`endif

endmodule

### rtl/core/iqlms_coef_ram.sv
// iqlms_coef_ram: coefficient table, one write port and one registered read port
// depends on iqlms_pkg (coef_t)
module iqlms_coef_ram #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  iqlms_pkg::coef_t      wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output iqlms_pkg::coef_t      rdata
);

  iqlms_pkg::coef_t mem [DEPTH];
  iqlms_pkg::coef_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/iqlms_datapath.sv
// iqlms_datapath: four-stage correction and lms update pipeline with output register
// depends on iqlms_pkg; reads coefficients from iqlms_coef_ram, writes them back
module iqlms_datapath #(
  parameter int unsigned ADDR_W = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [3:0]            step_shift,
  input  logic                  in_fire,
  input  iqlms_pkg::in_item_t   in_item,
  input  logic [ADDR_W-1:0]     in_idx,
  output logic                  take_ok,
  output logic                  hit,
  input  iqlms_pkg::coef_t      coef_rd,
  output logic                  wb_we,
  output logic [ADDR_W-1:0]     wb_addr,
  output iqlms_pkg::coef_t      wb_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output iqlms_pkg::out_item_t  out_data
);

  // stage a: item and table read
  logic                     a_valid_r;
  iqlms_pkg::in_item_t      a_item_r;
  logic [ADDR_W-1:0]        a_idx_r;
  // stage b: products of both corrections
  logic                     b_valid_r;
  logic [ADDR_W-1:0]        b_idx_r;
  iqlms_pkg::coef_t         b_w_r;
  logic signed [15:0]       b_y_re_r, b_y_im_r, b_m_re_r, b_m_ic_r;
  logic signed [31:0]       b_pt1_r [4];
  logic signed [31:0]       b_pt2_r [4];
  // stage c: corrected bins
  logic                     c_valid_r;
  logic [ADDR_W-1:0]        c_idx_r;
  iqlms_pkg::coef_t         c_w_r;
  logic signed [15:0]       c_m_re_r, c_m_ic_r;
  iqlms_pkg::out_item_t     c_res_r;
  // stage d: error products
  logic                     d_valid_r;
  logic [ADDR_W-1:0]        d_idx_r;
  iqlms_pkg::coef_t         d_w_r;
  iqlms_pkg::out_item_t     d_res_r;
  logic signed [31:0]       d_pe_r [4];
  // output register
  logic                     out_valid_r;
  iqlms_pkg::out_item_t     out_data_r;

  logic out_free, d_free, c_free, b_free, a_free;

  logic signed [15:0] a_wr, a_wi, a_wic, a_mic, a_yic;
  logic signed [31:0] a_pt1 [4];
  logic signed [31:0] a_pt2 [4];
  logic [32:0]        b_s1r, b_s1i, b_s2r, b_s2i;
  logic signed [15:0] b_t1r, b_t1i, b_t2r, b_t2i;
  iqlms_pkg::out_item_t b_res;
  logic signed [31:0] c_pe [4];
  logic [32:0]        d_ser, d_sei;
  logic signed [15:0] d_er, d_ei;
  iqlms_pkg::coef_t   d_wnew;

  assign out_free = !out_valid_r || out_ready;
  assign d_free   = !d_valid_r || out_free;
  assign c_free   = !c_valid_r || d_free;
  assign b_free   = !b_valid_r || c_free;
  assign a_free   = !a_valid_r || b_free;
  assign take_ok  = a_free;

  // entries still in flight have not been written back yet
  assign hit = (a_valid_r && (a_idx_r == in_idx)) || (b_valid_r && (b_idx_r == in_idx)) ||
               (c_valid_r && (c_idx_r == in_idx)) || (d_valid_r && (d_idx_r == in_idx));

  // stage a: W*conj(Ymir) and conj(W)*conj(Y) partial products
  always_comb begin
    a_wr  = coef_rd.re;
    a_wi  = coef_rd.im;
    a_wic = -a_wi;
    a_mic = -a_item_r.mirror_im;
    a_yic = -a_item_r.bin_im;
    a_pt1[0] = a_wr * a_item_r.mirror_re;
    a_pt1[1] = a_wi * a_mic;
    a_pt1[2] = a_wr * a_mic;
    a_pt1[3] = a_wi * a_item_r.mirror_re;
    a_pt2[0] = a_wr * a_item_r.bin_re;
    a_pt2[1] = a_wic * a_yic;
    a_pt2[2] = a_wr * a_yic;
    a_pt2[3] = a_wic * a_item_r.bin_re;
  end

  // stage b: sums, q15 truncation and subtraction
  always_comb begin
    b_s1r = {b_pt1_r[0][31], b_pt1_r[0]} - {b_pt1_r[1][31], b_pt1_r[1]};
    b_s1i = {b_pt1_r[2][31], b_pt1_r[2]} + {b_pt1_r[3][31], b_pt1_r[3]};
    b_s2r = {b_pt2_r[0][31], b_pt2_r[0]} - {b_pt2_r[1][31], b_pt2_r[1]};
    b_s2i = {b_pt2_r[2][31], b_pt2_r[2]} + {b_pt2_r[3][31], b_pt2_r[3]};
    b_t1r = b_s1r[30:15];
    b_t1i = b_s1i[30:15];
    b_t2r = b_s2r[30:15];
    b_t2i = b_s2i[30:15];
    b_res.fixed_re        = b_y_re_r - b_t1r;
    b_res.fixed_im        = b_y_im_r - b_t1i;
    b_res.fixed_mirror_re = b_m_re_r - b_t2r;
    b_res.fixed_mirror_im = (-b_m_ic_r) - b_t2i;
  end

  // stage c: Ycorr(k)*conj(Ymir) partial products
  always_comb begin
    c_pe[0] = c_res_r.fixed_re * c_m_re_r;
    c_pe[1] = c_res_r.fixed_im * c_m_ic_r;
    c_pe[2] = c_res_r.fixed_re * c_m_ic_r;
    c_pe[3] = c_res_r.fixed_im * c_m_re_r;
  end

  // stage d: error term, step shift and coefficient update
  always_comb begin
    d_ser     = {d_pe_r[0][31], d_pe_r[0]} - {d_pe_r[1][31], d_pe_r[1]};
    d_sei     = {d_pe_r[2][31], d_pe_r[2]} + {d_pe_r[3][31], d_pe_r[3]};
    d_er      = d_ser[30:15];
    d_ei      = d_sei[30:15];
    d_wnew.re = d_w_r.re + (d_er >>> step_shift);
    d_wnew.im = d_w_r.im + (d_ei >>> step_shift);
  end

  assign wb_we   = d_valid_r && out_free;
  assign wb_addr = d_idx_r;
  assign wb_data = d_wnew;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_r <= in_fire;
      end
      if (b_free) begin
        b_valid_r <= a_valid_r;
      end
      if (c_free) begin
        c_valid_r <= b_valid_r;
      end
      if (d_free) begin
        d_valid_r <= c_valid_r;
      end
      if (out_free) begin
        out_valid_r <= d_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item_r <= in_item;
      a_idx_r  <= in_idx;
    end
    if (b_free) begin
      b_idx_r  <= a_idx_r;
      b_w_r    <= coef_rd;
      b_y_re_r <= a_item_r.bin_re;
      b_y_im_r <= a_item_r.bin_im;
      b_m_re_r <= a_item_r.mirror_re;
      b_m_ic_r <= a_mic;
      b_pt1_r  <= a_pt1;
      b_pt2_r  <= a_pt2;
    end
    if (c_free) begin
      c_idx_r  <= b_idx_r;
      c_w_r    <= b_w_r;
      c_m_re_r <= b_m_re_r;
      c_m_ic_r <= b_m_ic_r;
      c_res_r  <= b_res;
    end
    if (d_free) begin
      d_idx_r <= c_idx_r;
      d_w_r   <= c_w_r;
      d_res_r <= c_res_r;
      d_pe_r  <= c_pe;
    end
    if (out_free) begin
      out_data_r <= d_res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // the interlock keeps every in-flight entry unique
  a_no_dup_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !((a_valid_r && b_valid_r && (a_idx_r == b_idx_r)) ||
      (a_valid_r && c_valid_r && (a_idx_r == c_idx_r)) ||
      (a_valid_r && d_valid_r && (a_idx_r == d_idx_r)) ||
      (b_valid_r && c_valid_r && (b_idx_r == c_idx_r)) ||
      (b_valid_r && d_valid_r && (b_idx_r == d_idx_r)) ||
      (c_valid_r && d_valid_r && (c_idx_r == d_idx_r))))
    else $error("two in-flight items share one coefficient entry");

  // a written-back item lands in the output register
  a_wb_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    wb_we |=> (out_valid_r && (out_data_r == $past(d_res_r))))
    else $error("written-back item did not reach the output register");
`endif

endmodule
